FILE: hdl/baseline_hazard_estimator_top_macros.svh
// Assertion macros for the baseline hazard estimator.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef BASELINE_HAZARD_ESTIMATOR_TOP_MACROS_SVH
`define BASELINE_HAZARD_ESTIMATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BHE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("baseline hazard estimator assertion failed");

// Next-cycle implication, checked outside reset.
`define BHE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("baseline hazard estimator assertion failed");

`endif

FILE: hdl/bhe_pkg.sv
// Package for the baseline hazard estimator: word types, op codes, states
// and default sizes. No dependencies.
package bhe_pkg;

    localparam int MAX_ROWS_DEF       = 4096;
    localparam int TIME_BITS_DEF      = 32;
    localparam int RISK_FRAC_BITS_DEF = 16;
    localparam int STRATUM_BITS_DEF   = 8;
    localparam int OUT_FRAC_BITS      = 16;
    localparam logic [47:0] MAX48     = 48'hFFFF_FFFF_FFFF;
    localparam logic [12:0] MAX_COUNT = 13'd8191;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] start_time;
        logic [31:0] end_time;
        logic        event_flag;
        logic [7:0]  row_stratum;
        logic [31:0] risk_value;
        logic [31:0] query_time;
        logic [7:0]  query_stratum;
    } in_item_t;

    typedef struct packed {
        logic [47:0] hazard;
        logic [47:0] hazard_variance;
        logic [12:0] event_count;
        logic        zero_risk_flag;
        logic        saturated_flag;
        logic        store_full_flag;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV1,
        ST_DIV2,
        ST_DIV3,
        ST_FIN
    } state_t;

endpackage

FILE: hdl/bhe_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module bhe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/bhe_div.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module bhe_div #(
    parameter int NW = 64,
    parameter int DW = 48
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW-1:0] r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   r_sh;
    logic          take;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        r_sh      = {r_reg, q_reg[NW-1]};
        take      = r_sh >= {1'b0, d_reg};
        if (start) begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            r_next   = take ? DW'(r_sh - {1'b0, d_reg}) : DW'(r_sh);
            q_next   = {q_reg[NW-2:0], take};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

FILE: hdl/baseline_hazard_estimator_top.sv
// Top level of the baseline hazard estimator: row store, scan and divide control.
// Depends on bhe_pkg, bhe_ram, bhe_div and the assertion macro header.
//
//   channel   ports                         direction
//   input     s_valid s_ready s_data        in   (load, query, clear words)
//   result    m_valid m_ready m_data        out  (one word per query)
//   config    cfg_valid cfg_ready cfg_data  in   (strata_mode)
//
// Loads and clears are taken in the idle state. A query scans the row RAM read port,
// then, unless no event matched or the risk sum is zero, runs three serial divisions
// in the shared divider, and then loads the output register once it is free or read;
// the result word is then valid on the result channel.
// Reset is synchronous and needs no clearing pass; the fill count guards the RAM.
// A finished result waits in the output register; loads and clears go on meanwhile.
`include "baseline_hazard_estimator_top_macros.svh"
module baseline_hazard_estimator_top #(
    parameter int MAX_ROWS       = bhe_pkg::MAX_ROWS_DEF,
    parameter int TIME_BITS      = bhe_pkg::TIME_BITS_DEF,
    parameter int RISK_FRAC_BITS = bhe_pkg::RISK_FRAC_BITS_DEF,
    parameter int STRATUM_BITS   = bhe_pkg::STRATUM_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bhe_pkg::in_item_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bhe_pkg::out_item_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    import bhe_pkg::*;

    localparam int AW    = $clog2(MAX_ROWS);
    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int SUM_W = 32 + CNT_W;
    localparam int NW    = CNT_W + 2 * RISK_FRAC_BITS + OUT_FRAC_BITS;
    localparam int QX    = (NW > 49) ? NW : 49;
    localparam int CX    = (CNT_W > 13) ? CNT_W : 13;
    localparam int RW    = 33 + STRATUM_BITS + 2 * TIME_BITS;
    localparam int O_EV  = 32 + STRATUM_BITS;
    localparam int O_END = 33 + STRATUM_BITS;
    localparam int O_STA = 33 + STRATUM_BITS + TIME_BITS;

    state_t                  state_reg, state_next;
    logic                    mode_reg, mode_next;
    logic [CNT_W-1:0]        rows_reg, rows_next;
    logic                    drop_reg, drop_next;
    logic [TIME_BITS-1:0]    t_reg, t_next;
    logic [STRATUM_BITS-1:0] qs_reg, qs_next;
    logic [CNT_W-1:0]        issue_reg, issue_next;
    logic                    pend_reg, pend_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [47:0]             hz_reg, hz_next;
    logic [47:0]             var_reg, var_next;
    logic                    zr_reg, zr_next;
    logic                    sat_reg, sat_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg, m_data_next;

    logic                    we, re;
    logic [RW-1:0]           wdata, rdata;
    logic                    div_start, div_done;
    logic [NW-1:0]           div_num, div_quot;
    logic                    s_fire;
    logic [TIME_BITS-1:0]    rs, re_t;
    logic                    match, risk_ok, ev_ok;
    logic [CX-1:0]           count_x;

    bhe_ram #(.WIDTH(RW), .DEPTH(MAX_ROWS)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (rows_reg[AW-1:0]),
        .wdata (wdata),
        .re    (re),
        .raddr (issue_reg[AW-1:0]),
        .rdata (rdata)
    );

    bhe_div #(.NW(NW), .DW(SUM_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (sum_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    function automatic logic [47:0] clip48(input logic [NW-1:0] q);
        logic [QX-1:0] qx;
        qx = QX'(q);
        return (qx > QX'(MAX48)) ? MAX48 : qx[47:0];
    endfunction

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign wdata     = {TIME_BITS'(s_data.start_time), TIME_BITS'(s_data.end_time),
                        s_data.event_flag, STRATUM_BITS'(s_data.row_stratum),
                        s_data.risk_value};
    assign we        = s_fire && (s_data.op == OP_LOAD) && (rows_reg < CNT_W'(MAX_ROWS));
    assign re        = (state_reg == ST_SCAN) && (issue_reg < rows_reg);

    assign rs      = rdata[O_STA +: TIME_BITS];
    assign re_t    = rdata[O_END +: TIME_BITS];
    assign match   = (rdata[32 +: STRATUM_BITS] == qs_reg);
    assign risk_ok = mode_reg ? (((rs < t_reg) || (rs == re_t)) && (re_t >= t_reg) && match)
                              : ((rs <= t_reg) && (re_t >= t_reg));
    assign ev_ok   = rdata[O_EV] && (re_t == t_reg) && (!mode_reg || match);
    assign count_x = CX'(count_reg);

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        rows_next    = rows_reg;
        drop_next    = drop_reg;
        t_next       = t_reg;
        qs_next      = qs_reg;
        issue_next   = issue_reg;
        pend_next    = re;
        count_next   = count_reg;
        sum_next     = sum_reg;
        hz_next      = hz_reg;
        var_next     = var_reg;
        zr_next      = zr_reg;
        sat_next     = sat_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;
        div_num      = NW'(count_reg) << (RISK_FRAC_BITS + OUT_FRAC_BITS);

        if (cfg_valid) begin
            mode_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_data.op)
                        OP_LOAD: begin
                            if (rows_reg < CNT_W'(MAX_ROWS)) begin
                                rows_next = rows_reg + CNT_W'(1);
                            end else begin
                                drop_next = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            rows_next = '0;
                            drop_next = 1'b0;
                        end
                        OP_QUERY: begin
                            t_next     = TIME_BITS'(s_data.query_time);
                            qs_next    = STRATUM_BITS'(s_data.query_stratum);
                            issue_next = '0;
                            count_next = '0;
                            sum_next   = '0;
                            hz_next    = '0;
                            var_next   = '0;
                            zr_next    = 1'b0;
                            sat_next   = 1'b0;
                            state_next = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (pend_reg) begin
                    if (risk_ok) begin
                        sum_next = sum_reg + SUM_W'(rdata[31:0]);
                    end
                    if (ev_ok) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                if (re) begin
                    issue_next = issue_reg + CNT_W'(1);
                end else if (!pend_reg) begin
                    if (count_reg == '0) begin
                        state_next = ST_FIN;
                    end else if (sum_reg == '0) begin
                        hz_next    = MAX48;
                        var_next   = MAX48;
                        zr_next    = 1'b1;
                        sat_next   = 1'b1;
                        state_next = ST_FIN;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV1;
                    end
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    hz_next    = clip48(div_quot);
                    sat_next   = sat_reg || (clip48(div_quot) == MAX48 &&
                                 QX'(div_quot) > QX'(MAX48));
                    div_num    = NW'(count_reg) << (2 * RISK_FRAC_BITS + OUT_FRAC_BITS);
                    div_start  = 1'b1;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (div_done) begin
                    div_num    = div_quot;
                    div_start  = 1'b1;
                    state_next = ST_DIV3;
                end
            end
            ST_DIV3: begin
                if (div_done) begin
                    var_next   = clip48(div_quot);
                    sat_next   = sat_reg || (QX'(div_quot) > QX'(MAX48));
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.hazard          = hz_reg;
                    m_data_next.hazard_variance = var_reg;
                    m_data_next.event_count     = (count_x > CX'(MAX_COUNT)) ? MAX_COUNT
                                                                             : count_x[12:0];
                    m_data_next.zero_risk_flag  = zr_reg;
                    m_data_next.saturated_flag  = sat_reg;
                    m_data_next.store_full_flag = drop_reg;
                    state_next                  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= 1'b0;
            rows_reg    <= '0;
            drop_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            rows_reg    <= rows_next;
            drop_reg    <= drop_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        t_reg      <= t_next;
        qs_reg     <= qs_next;
        issue_reg  <= issue_next;
        count_reg  <= count_next;
        sum_reg    <= sum_next;
        hz_reg     <= hz_next;
        var_reg    <= var_next;
        zr_reg     <= zr_next;
        sat_reg    <= sat_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `BHE_ASSERT_NOW(a_fill_bound, 1'b1, rows_reg <= CNT_W'(MAX_ROWS))
    `BHE_ASSERT_NOW(a_zero_risk_sat, m_valid && m_data.zero_risk_flag,
                    m_data.saturated_flag && m_data.event_count != 13'd0)
    `BHE_ASSERT_NEXT(a_query_scans, s_valid && s_ready && s_data.op == OP_QUERY,
                     state_reg == ST_SCAN)

endmodule
